[design/keystream_rotation_cipher_macros.svh]
// Assertion macros shared by the keystream rotation cipher RTL.
`ifndef KEYSTREAM_ROTATION_CIPHER_MACROS_SVH
`define KEYSTREAM_ROTATION_CIPHER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KRC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keystream_rotation_cipher: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define KRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keystream_rotation_cipher: next-cycle check failed");

`endif

[design/krc_pkg.sv]
// Package with constants and arithmetic helpers of the keystream rotation cipher.
package krc_pkg;

    localparam int CHAR_W   = 7;
    localparam int SEED_W   = 16;
    localparam int STATE_W  = 17;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W   = 23;
    localparam int HIGH_W   = PROD_W - SEED_W;

    localparam logic [STATE_W-1:0] SEED_RESET = 17'd1;
    localparam logic [STATE_W-1:0] LEHMER_MOD = 17'd65537;
    localparam logic [CHAR_W-1:0]  PRINT_BASE = 7'd32;
    localparam logic [CHAR_W-1:0]  PRINT_SPAN = 7'd96;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_SEED   = 2'd0,
        REG_DECRYPT_MODE = 2'd1
    } cfg_reg_t;

    // One Lehmer step: (s * 75) mod 65537, using 2^16 = -1 modulo 65537.
    function automatic logic [STATE_W-1:0] advance_state(input logic [STATE_W-1:0] s);
        logic [PROD_W-1:0] prod;
        logic [STATE_W-1:0] low;
        logic [STATE_W-1:0] high;
        begin
            // 75 = 64 + 8 + 2 + 1
            prod = {s, 6'd0} + {3'd0, s, 3'd0} + {5'd0, s, 1'b0} + {6'd0, s};
            low  = {1'b0, prod[SEED_W-1:0]};
            high = {{(STATE_W - HIGH_W){1'b0}}, prod[PROD_W-1:SEED_W]};
            if (low >= high)
                advance_state = low - high;
            else
                advance_state = low + LEHMER_MOD - high;
        end
    endfunction

    // State modulo 96: 96 = 3 * 32, so the remainder is ((s >> 5) mod 3) * 32 + s[4:0].
    // The mod 3 uses 4 = 1 (mod 3): base-4 digits are summed.
    function automatic logic [CHAR_W-1:0] rot_amount(input logic [STATE_W-1:0] s);
        logic [11:0] q;
        logic [4:0]  dsum;
        logic [2:0]  fold;
        logic [1:0]  r;
        begin
            q = s[STATE_W-1:5];
            dsum = 5'd0;
            for (int i = 0; i < 6; i++)
                dsum = dsum + {3'd0, q[2*i +: 2]};
            fold = {1'b0, dsum[1:0]} + {1'b0, dsum[3:2]} + {2'd0, dsum[4]};
            unique case (fold)
                3'd0, 3'd3, 3'd6: r = 2'd0;
                3'd1, 3'd4, 3'd7: r = 2'd1;
                default:          r = 2'd2;
            endcase
            rot_amount = {r, s[4:0]};
        end
    endfunction

endpackage

[design/keystream_rotation_cipher.sv]
// Top level of the keystream rotation cipher: generator, rotation and handshakes.
//
// Usage:
//   Input channel (in_valid/in_ready/in_char) takes one 7-bit character per item.
//   Output channel (out_valid/out_ready/out_char) returns one character per item,
//   in order. Codes below 32 pass through; codes 32..127 are rotated within that
//   range by the generator value modulo 96, backward when decrypt_mode is set.
//   Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always
//   ready. Index 0 loads the seed into the generator, index 1 sets decrypt_mode
//   from bit 0; other indexes are ignored. Write only while the block is idle.
//   Items pass the input register, then the output register; throughput is one
//   item per cycle while out_ready is high. The generator step sits in the input
//   stage and the modulo-96 rotation in the output stage, each one short add path.
//   Reset puts the generator at 1 and selects encryption; both stages empty.
//   When the receiver stalls, the result holds in the output register, one more
//   item waits in the input stage, and then in_ready drops until out_ready rises.
`include "keystream_rotation_cipher_macros.svh"

module keystream_rotation_cipher
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [krc_pkg::CHAR_W-1:0]    in_char,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [krc_pkg::CHAR_W-1:0]    out_char,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [krc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [krc_pkg::SEED_W-1:0]    cfg_data
);
    import krc_pkg::*;

    logic [STATE_W-1:0] key_state_reg;
    logic [STATE_W-1:0] key_state_next;
    logic               decrypt_reg;
    logic               decrypt_next;
    logic               s1_valid_reg;
    logic [CHAR_W-1:0]  s1_char_reg;
    logic               out_valid_reg;
    logic [CHAR_W-1:0]  out_char_reg;
    logic [CHAR_W-1:0]  out_char_next;
    logic               cfg_write;
    logic               in_accept;
    logic               s1_advance;
    logic [CHAR_W-1:0]  amount;
    logic [CHAR_W-1:0]  pos;
    logic [CHAR_W:0]    fwd_sum;
    logic [CHAR_W:0]    bwd_diff;
    logic [CHAR_W-1:0]  new_pos;

    assign cfg_ready  = 1'b1;
    assign cfg_write  = cfg_valid && cfg_ready;
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_accept  = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign out_char   = out_char_reg;

    // The generator steps when an item enters, so while the item waits in the
    // input stage key_state_reg holds exactly the value that keys it.
    always_comb
    begin
        key_state_next = key_state_reg;
        decrypt_next   = decrypt_reg;
        if (cfg_write && cfg_index == REG_START_SEED)
            key_state_next = {1'b0, cfg_data};
        else if (in_accept)
            key_state_next = advance_state(key_state_reg);
        if (cfg_write && cfg_index == REG_DECRYPT_MODE)
            decrypt_next = cfg_data[0];
    end

    always_comb
    begin
        amount   = rot_amount(key_state_reg);
        pos      = s1_char_reg - PRINT_BASE;
        fwd_sum  = {1'b0, pos} + {1'b0, amount};
        bwd_diff = {1'b0, pos} - {1'b0, amount};
        if (decrypt_reg)
        begin
            if (bwd_diff[CHAR_W])
                new_pos = bwd_diff[CHAR_W-1:0] + PRINT_SPAN;
            else
                new_pos = bwd_diff[CHAR_W-1:0];
        end
        else
        begin
            if (fwd_sum >= {1'b0, PRINT_SPAN})
                new_pos = fwd_sum[CHAR_W-1:0] - PRINT_SPAN;
            else
                new_pos = fwd_sum[CHAR_W-1:0];
        end
        if (s1_char_reg < PRINT_BASE)
            out_char_next = s1_char_reg;
        else
            out_char_next = new_pos + PRINT_BASE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_state_reg <= SEED_RESET;
            decrypt_reg   <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            key_state_reg <= key_state_next;
            decrypt_reg   <= decrypt_next;
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (!out_valid_reg || out_ready)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            s1_char_reg <= in_char;
        if (s1_advance)
            out_char_reg <= out_char_next;
    end

    `KRC_ASSERT_SAME(a_state_range, 1'b1, key_state_reg <= LEHMER_MOD - 17'd1)
    `KRC_ASSERT_SAME(a_amount_range, s1_valid_reg, amount < PRINT_SPAN)
    `KRC_ASSERT_SAME(a_stall_blocks_input, s1_valid_reg && out_valid_reg && !out_ready, !in_ready)
    `KRC_ASSERT_NEXT(a_control_passthrough, s1_advance && s1_char_reg < PRINT_BASE,
        out_char_reg == $past(s1_char_reg))

endmodule
